// File: sv/utf8_to_utf16_transcoder_core_assert.svh
// Assertion macros for the UTF-8 to UTF-16 transcoder core.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH

// check a condition at every rising clock edge outside reset
`define U8U16_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define U8U16_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies.
`default_nettype none

package u8u16_pkg;

  localparam logic [15:0] REPLACEMENT     = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE    = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE    = 16'hDC00;
  localparam logic [20:0] PLANE1_BASE     = 21'h010000;
  localparam logic [20:0] CODE_POINT_MAX  = 21'h10FFFF;

  localparam int          MAX_UNITS_BITS  = 16;
  localparam int          CFG_INDEX_BITS  = 1;
  localparam int          CFG_DATA_BITS   = 16;
  localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_UNITS    = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // work left for the back end by one input word
  typedef struct packed {
    logic [1:0]  pre_n;    // replacements for a broken sequence
    logic        cp_en;    // one code point to emit
    logic        cp_pair;  // code point needs a surrogate pair
    logic [15:0] cp_unit;  // single unit or high surrogate
    logic [15:0] cp_lo;    // low surrogate
    logic [1:0]  post_n;   // replacements for a truncated sequence
    logic        eos;      // end marker follows
  } plan_t;

endpackage

`default_nettype wire

// File: sv/u8u16_front.sv
// Front end: accepts input words, tracks the pending UTF-8 sequence and
// classifies each word into a plan. Uses u8u16_pkg.
`default_nettype none

module u8u16_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_string,
  input  wire logic              q_full,
  output logic                   push,
  output u8u16_pkg::plan_t       plan
);

  logic [1:0]  need;
  logic [1:0]  seen;
  logic [20:0] partial;
  logic [1:0]  need_next;
  logic [1:0]  seen_next;
  logic [20:0] partial_next;

  logic        pending;
  logic        is_suffix;
  logic [20:0] ext_part;
  logic [1:0]  seen_inc;
  logic        cp_take;
  logic [20:0] cp_val;
  logic [20:0] cp_off;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    pending      = (need != 2'd0);
    is_suffix    = (in_byte[7:6] == 2'b10);
    ext_part     = {partial[14:0], in_byte[5:0]};
    seen_inc     = seen + 2'd1;
    need_next    = need;
    seen_next    = seen;
    partial_next = partial;
    cp_take      = 1'b0;
    cp_val       = '0;
    plan         = '0;

    if (pending && is_suffix) begin
      partial_next = ext_part;
      seen_next    = seen_inc;
      if (seen_inc >= need) begin
        cp_take      = 1'b1;
        cp_val       = ext_part;
        need_next    = 2'd0;
        seen_next    = 2'd0;
        partial_next = '0;
      end
    end else begin
      if (pending) begin
        plan.pre_n   = seen_inc;
        need_next    = 2'd0;
        seen_next    = 2'd0;
        partial_next = '0;
      end
      priority if (in_byte < 8'h80) begin
        cp_take = 1'b1;
        cp_val  = {13'd0, in_byte};
      end else if (in_byte < 8'hC0) begin
        cp_take = 1'b1;
        cp_val  = {5'd0, u8u16_pkg::REPLACEMENT};
      end else if (in_byte < 8'hE0) begin
        need_next    = 2'd1;
        seen_next    = 2'd0;
        partial_next = {16'd0, in_byte[4:0]};
      end else if (in_byte < 8'hF0) begin
        need_next    = 2'd2;
        seen_next    = 2'd0;
        partial_next = {17'd0, in_byte[3:0]};
      end else if (in_byte < 8'hF8) begin
        need_next    = 2'd3;
        seen_next    = 2'd0;
        partial_next = {18'd0, in_byte[2:0]};
      end else begin
        cp_take = 1'b1;
        cp_val  = {5'd0, u8u16_pkg::REPLACEMENT};
      end
    end

    if (end_of_string) begin
      if (need_next != 2'd0) begin
        plan.post_n = seen_next + 2'd1;
      end
      plan.eos     = 1'b1;
      need_next    = 2'd0;
      seen_next    = 2'd0;
      partial_next = '0;
    end

    cp_off       = cp_val - u8u16_pkg::PLANE1_BASE;
    plan.cp_en   = cp_take;
    plan.cp_lo   = u8u16_pkg::LO_SURR_BASE + {6'd0, cp_off[9:0]};
    priority if (cp_val < u8u16_pkg::PLANE1_BASE) begin
      plan.cp_pair = 1'b0;
      plan.cp_unit = cp_val[15:0];
    end else if (cp_val > u8u16_pkg::CODE_POINT_MAX) begin
      plan.cp_pair = 1'b0;
      plan.cp_unit = u8u16_pkg::REPLACEMENT;
    end else begin
      plan.cp_pair = 1'b1;
      plan.cp_unit = u8u16_pkg::HI_SURR_BASE + {6'd0, cp_off[19:10]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need    <= 2'd0;
      seen    <= 2'd0;
      partial <= '0;
    end else if (push) begin
      need    <= need_next;
      seen    <= seen_next;
      partial <= partial_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/u8u16_queue.sv
// Short plan queue between the front and back ends of the transcoder.
// Uses u8u16_pkg and the assertion macro header.
`default_nettype none

module u8u16_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire u8u16_pkg::plan_t  plan_in,
  output logic                   full,
  input  wire logic              pop,
  output logic                   q_valid,
  output u8u16_pkg::plan_t       plan_out
);

  `include "utf8_to_utf16_transcoder_core_assert.svh"

  localparam int PTR_BITS = $clog2(u8u16_pkg::QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(u8u16_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(u8u16_pkg::QUEUE_DEPTH);
  localparam logic [PTR_BITS-1:0] LAST_C  = PTR_BITS'(u8u16_pkg::QUEUE_DEPTH - 1);

  u8u16_pkg::plan_t entries [u8u16_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;

  assign full     = (count == DEPTH_C);
  assign q_valid  = (count != '0);
  assign plan_out = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= plan_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      count <= count_next;
    end
  end

  `U8U16_CHECK(a_no_push_full, !(push && full), "plan pushed into full queue")
  `U8U16_CHECK(a_no_pop_empty, !(pop && !q_valid), "plan popped from empty queue")
  `U8U16_CHECK(a_count_bound, count <= DEPTH_C, "queue count past its depth")

endmodule

`default_nettype wire

// File: sv/u8u16_back.sv
// Back end: carries out plans one result word per cycle while the output is
// not held, applies the unit limit and drives the output register. Uses u8u16_pkg and the assertion header.
`default_nettype none

module u8u16_back #(
  parameter int UNIT_COUNT_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_valid,
  input  wire u8u16_pkg::plan_t                      plan_in,
  output logic                                       pop,
  input  wire logic                                  limit_enable,
  input  wire logic [u8u16_pkg::MAX_UNITS_BITS-1:0]  max_units,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [15:0]                                code_unit,
  output logic                                       unit_valid,
  output logic                                       string_done,
  output logic                                       run_last
);

  `include "utf8_to_utf16_transcoder_core_assert.svh"

  localparam int CW = ((UNIT_COUNT_BITS > u8u16_pkg::MAX_UNITS_BITS) ?
                       UNIT_COUNT_BITS : u8u16_pkg::MAX_UNITS_BITS) + 2;
  localparam logic [UNIT_COUNT_BITS-1:0] COUNT_TOP = {UNIT_COUNT_BITS{1'b1}};

  logic [1:0]  pre;
  logic        cp_pend;
  logic        cp_pair;
  logic [15:0] cp_unit;
  logic [15:0] lo_unit;
  logic        lo_pend;
  logic [1:0]  post;
  logic        eos_pend;
  logic [UNIT_COUNT_BITS-1:0] units_written;
  logic        halted;

  logic [1:0]  pre_next;
  logic        cp_pend_next;
  logic        lo_pend_next;
  logic [1:0]  post_next;
  logic        eos_pend_next;
  logic [UNIT_COUNT_BITS-1:0] units_written_next;
  logic        halted_next;

  logic        sel_pre, sel_cp, sel_lo, sel_post, sel_mark;
  logic        busy, step, advance, checking, fits, produce, busy_after;
  logic [1:0]  need_cur, need_after;
  logic [CW-1:0] sum_cur, sum_after, max_w;
  logic        fits_after, more;
  logic [15:0] unit_sel;

  always_comb begin
    max_w    = CW'(max_units);
    sel_pre  = !halted && (pre != 2'd0);
    sel_cp   = !halted && !sel_pre && cp_pend;
    sel_lo   = !sel_pre && !sel_cp && lo_pend;
    sel_post = !halted && !sel_pre && !sel_cp && !lo_pend && (post != 2'd0);
    sel_mark = !sel_pre && !sel_cp && !lo_pend && !sel_post && eos_pend;
    busy     = sel_pre || sel_cp || sel_lo || sel_post || sel_mark;
    advance  = !out_valid || out_ready;
    step     = busy && advance;
    checking = sel_pre || sel_cp || sel_post;

    need_cur = (sel_cp && cp_pair) ? 2'd2 : 2'd1;
    sum_cur  = CW'(units_written) + CW'(need_cur);
    fits     = !limit_enable || (sum_cur <= max_w);

    pre_next           = pre;
    cp_pend_next       = cp_pend;
    lo_pend_next       = lo_pend;
    post_next          = post;
    eos_pend_next      = eos_pend;
    units_written_next = units_written;
    halted_next        = halted;

    if (step) begin
      if (checking) begin
        if (fits) begin
          units_written_next = (sum_cur > CW'(COUNT_TOP)) ? COUNT_TOP :
                               sum_cur[UNIT_COUNT_BITS-1:0];
          if (sel_pre) begin
            pre_next = pre - 2'd1;
          end else if (sel_cp) begin
            cp_pend_next = 1'b0;
            lo_pend_next = cp_pair;
          end else begin
            post_next = post - 2'd1;
          end
        end else begin
          halted_next  = 1'b1;
          pre_next     = 2'd0;
          cp_pend_next = 1'b0;
          post_next    = 2'd0;
        end
      end else if (sel_lo) begin
        lo_pend_next = 1'b0;
      end else begin
        eos_pend_next      = 1'b0;
        pre_next           = 2'd0;
        cp_pend_next       = 1'b0;
        post_next          = 2'd0;
        units_written_next = '0;
        halted_next        = 1'b0;
      end
    end

    // decide whether this word is the last one for its input word
    need_after = ((pre_next == 2'd0) && cp_pend_next && cp_pair) ? 2'd2 : 2'd1;
    sum_after  = CW'(units_written_next) + CW'(need_after);
    fits_after = !limit_enable || (sum_after <= max_w);
    more       = lo_pend_next || eos_pend_next ||
                 (((pre_next != 2'd0) || cp_pend_next || (post_next != 2'd0)) &&
                  fits_after);
    busy_after = lo_pend_next || eos_pend_next ||
                 (!halted_next &&
                  ((pre_next != 2'd0) || cp_pend_next || (post_next != 2'd0)));

    produce = step && ((checking && fits) || sel_lo || sel_mark);
    pop     = q_valid && (!busy || (step && !busy_after));

    unit_sel = u8u16_pkg::REPLACEMENT;
    if (sel_cp) begin
      unit_sel = cp_unit;
    end else if (sel_lo) begin
      unit_sel = lo_unit;
    end else if (sel_mark) begin
      unit_sel = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre           <= 2'd0;
      cp_pend       <= 1'b0;
      lo_pend       <= 1'b0;
      post          <= 2'd0;
      eos_pend      <= 1'b0;
      units_written <= '0;
      halted        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      units_written <= units_written_next;
      halted        <= halted_next;
      if (pop) begin
        pre      <= plan_in.pre_n;
        cp_pend  <= plan_in.cp_en;
        lo_pend  <= 1'b0;
        post     <= plan_in.post_n;
        eos_pend <= plan_in.eos;
      end else begin
        pre      <= pre_next;
        cp_pend  <= cp_pend_next;
        lo_pend  <= lo_pend_next;
        post     <= post_next;
        eos_pend <= eos_pend_next;
      end
      if (advance) begin
        out_valid <= produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cp_pair <= plan_in.cp_pair;
      cp_unit <= plan_in.cp_unit;
      lo_unit <= plan_in.cp_lo;
    end
    if (produce) begin
      code_unit   <= unit_sel;
      unit_valid  <= !sel_mark;
      string_done <= sel_mark;
      run_last    <= !more;
    end
  end

  `U8U16_CHECK(a_low_not_halted, !(lo_pend && halted), "low surrogate pending while halted")
  `U8U16_CHECK_NEXT(a_marker_clears, step && sel_mark,
                    (units_written == '0) && !halted, "string state not cleared")
  `U8U16_CHECK(a_kind_exclusive, !out_valid || (unit_valid != string_done),
               "result word is neither unit nor marker")

endmodule

`default_nettype wire

// File: sv/utf8_to_utf16_transcoder_core.sv
// UTF-8 to UTF-16 transcoder, top level: configuration registers, front
// end, plan queue and back end. Uses u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
//
// Takes one UTF-8 byte per cycle while the plan queue has room and returns
// UTF-16 code units, one result word per cycle while the output is accepted,
// each string closed by an end-marker word. A byte enters the front end in
// the cycle it is offered, unless the two-entry plan queue is full; the back
// end then produces the result words that the byte causes (none to five), and
// each result passes through the plan queue, the back end's plan registers
// and the output register. The back end and its single output register set
// the sustained rate: one byte per cycle for bytes with at most one result.
// Configuration takes effect at once; there is no clearing pass after reset.
`default_nettype none

module utf8_to_utf16_transcoder_core #(
  parameter int UNIT_COUNT_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [7:0]                            in_byte,
  input  wire logic                                  end_of_string,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [15:0]                                code_unit,
  output logic                                       unit_valid,
  output logic                                       string_done,
  output logic                                       run_last,
  input  wire logic                                  cfg_write,
  input  wire logic [u8u16_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [u8u16_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic                                  limit_enable;
  logic [u8u16_pkg::MAX_UNITS_BITS-1:0]  max_units;
  logic                                  push;
  logic                                  pop;
  logic                                  q_full;
  logic                                  q_valid;
  u8u16_pkg::plan_t                      plan_push;
  u8u16_pkg::plan_t                      plan_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enable <= 1'b0;
      max_units    <= u8u16_pkg::MAX_UNITS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        u8u16_pkg::CFG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        u8u16_pkg::CFG_MAX_UNITS:    max_units    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .push          (push),
    .plan          (plan_push)
  );

  u8u16_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .plan_in  (plan_push),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .plan_out (plan_head)
  );

  u8u16_back #(
    .UNIT_COUNT_BITS (UNIT_COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .plan_in      (plan_head),
    .pop          (pop),
    .limit_enable (limit_enable),
    .max_units    (max_units),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_unit    (code_unit),
    .unit_valid   (unit_valid),
    .string_done  (string_done),
    .run_last     (run_last)
  );

endmodule

`default_nettype wire

// File: bench/utf8_to_utf16_transcoder_core_tb.sv
// Testbench for utf8_to_utf16_transcoder_core: UTF-8 bytes in, UTF-16 words out.
// A directed table, partly scored against fixed expected words, then random
// strings scored against a decoder predictor; uses u8u16_pkg.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_core_tb;

  typedef struct packed {
    logic [15:0] cu;
    logic        is_unit;
    logic        done;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        eos;
    logic        typed;
    logic [15:0] cu;
  } dir_row_t;

  localparam int N_DIR = 26;
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    '{8'h00, 1'b0, 1'b1, 16'h0000},
    '{8'h7F, 1'b0, 1'b1, 16'h007F},
    '{8'h80, 1'b0, 1'b1, 16'hFFFD},
    '{8'hF8, 1'b0, 1'b1, 16'hFFFD},
    '{8'hFF, 1'b1, 1'b1, 16'hFFFD},
    '{8'hC3, 1'b0, 1'b0, 16'h0000},
    '{8'hA9, 1'b0, 1'b0, 16'h0000},
    '{8'hE2, 1'b0, 1'b0, 16'h0000},
    '{8'h82, 1'b0, 1'b0, 16'h0000},
    '{8'hAC, 1'b0, 1'b0, 16'h0000},
    '{8'hF0, 1'b0, 1'b0, 16'h0000},
    '{8'h9F, 1'b0, 1'b0, 16'h0000},
    '{8'h98, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'hF7, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hE2, 1'b0, 1'b0, 16'h0000},
    '{8'h82, 1'b0, 1'b0, 16'h0000},
    '{8'h41, 1'b0, 1'b0, 16'h0000},
    '{8'hF0, 1'b0, 1'b0, 16'h0000},
    '{8'h9F, 1'b0, 1'b0, 16'h0000},
    '{8'h98, 1'b0, 1'b0, 16'h0000},
    '{8'hF8, 1'b1, 1'b0, 16'h0000},
    '{8'hC3, 1'b1, 1'b0, 16'h0000}
  };

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [7:0]                           in_byte = 8'h00;
  logic                                 end_of_string = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [15:0]                          code_unit;
  logic                                 unit_valid;
  logic                                 string_done;
  logic                                 run_last;
  logic                                 cfg_write = 1'b0;
  logic [u8u16_pkg::CFG_INDEX_BITS-1:0] cfg_index = u8u16_pkg::CFG_LIMIT_ENABLE;
  logic [u8u16_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  utf8_to_utf16_transcoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_unit     (code_unit),
    .unit_valid    (unit_valid),
    .string_done   (string_done),
    .run_last      (run_last),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // decoder state and register copies
  logic        limit_on = 1'b0;
  logic [15:0] unit_cap = u8u16_pkg::MAX_UNITS_RESET;
  logic [1:0]  need_sfx = '0;
  logic [1:0]  seen_sfx = '0;
  logic [20:0] partial = '0;
  logic [15:0] units_done = '0;
  logic        halted = 1'b0;

  word_t       step_words [0:4];
  int          step_n;
  word_t       expected_words [$];
  logic [7:0]  str_bytes [$];

  bit calm = 1'b0;
  bit hold_go = 1'b0;
  int mismatches = 0;
  int words_checked = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int settings_run = 1;

  function automatic void expect_word(word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void add_str_byte(logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endfunction

  function automatic void put_word(logic [15:0] cu, logic is_unit, logic done);
    if (step_n < 5) begin
      step_words[step_n] = '{cu, is_unit, done, 1'b0};
      step_n++;
    end
  endfunction

  function automatic void emit_code_point(logic [20:0] cp);
    int need;
    logic [20:0] v;
    if (halted) return;
    need = (cp < u8u16_pkg::PLANE1_BASE || cp > u8u16_pkg::CODE_POINT_MAX) ? 1 : 2;
    if (limit_on && int'(units_done) + need > int'(unit_cap)) begin
      halted = 1'b1;
      return;
    end
    if (cp < u8u16_pkg::PLANE1_BASE) begin
      put_word(cp[15:0], 1'b1, 1'b0);
    end else if (cp > u8u16_pkg::CODE_POINT_MAX) begin
      put_word(u8u16_pkg::REPLACEMENT, 1'b1, 1'b0);
    end else begin
      v = cp - u8u16_pkg::PLANE1_BASE;
      put_word(u8u16_pkg::HI_SURR_BASE + {6'b0, v[19:10]}, 1'b1, 1'b0);
      if (units_done != 16'hFFFF) units_done++;
      put_word(u8u16_pkg::LO_SURR_BASE + {6'b0, v[9:0]}, 1'b1, 1'b0);
    end
    if (units_done != 16'hFFFF) units_done++;
  endfunction

  function automatic void clear_seq();
    need_sfx = '0;
    seen_sfx = '0;
    partial = '0;
  endfunction

  function automatic void flush_broken();
    int n;
    n = 1 + seen_sfx;
    for (int i = 0; i < n; i++) emit_code_point({5'b0, u8u16_pkg::REPLACEMENT});
    clear_seq();
  endfunction

  function automatic void lead_in(logic [7:0] b);
    if (b < 8'h80) begin
      emit_code_point({13'b0, b});
    end else if (b < 8'hC0) begin
      emit_code_point({5'b0, u8u16_pkg::REPLACEMENT});
    end else if (b < 8'hE0) begin
      need_sfx = 2'd1; seen_sfx = '0; partial = {16'b0, b[4:0]};
    end else if (b < 8'hF0) begin
      need_sfx = 2'd2; seen_sfx = '0; partial = {17'b0, b[3:0]};
    end else if (b < 8'hF8) begin
      need_sfx = 2'd3; seen_sfx = '0; partial = {18'b0, b[2:0]};
    end else begin
      emit_code_point({5'b0, u8u16_pkg::REPLACEMENT});
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eos);
    logic [20:0] cp;
    step_n = 0;
    if (need_sfx != 0) begin
      if (b[7:6] == 2'b10) begin
        partial = {partial[14:0], b[5:0]};
        seen_sfx++;
        if (seen_sfx >= need_sfx) begin
          cp = partial;
          clear_seq();
          emit_code_point(cp);
        end
      end else begin
        flush_broken();
        lead_in(b);
      end
    end else begin
      lead_in(b);
    end
    if (eos) begin
      if (need_sfx != 0) flush_broken();
      put_word(16'h0000, 1'b0, 1'b1);
      clear_seq();
      units_done = '0;
      halted = 1'b0;
    end
    if (step_n > 0) step_words[step_n-1].last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input logic [15:0] cu);
    int gap;
    if (!calm && $urandom_range(99) < 5) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, eos);
    if (typed) begin
      expect_word('{cu, 1'b1, 1'b0, !eos});
      if (eos) expect_word('{16'h0000, 1'b0, 1'b1, 1'b1});
    end else begin
      for (int i = 0; i < step_n; i++) expect_word(step_words[i]);
    end
    bytes_sent++;
  endtask

  // drop valid and wait for the pipeline to drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_limits(input logic en, input logic [15:0] cap);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= u8u16_pkg::CFG_LIMIT_ENABLE;
    cfg_data <= {15'b0, en};
    @(posedge clk);
    limit_on = en;
    @(negedge clk);
    cfg_index <= u8u16_pkg::CFG_MAX_UNITS;
    cfg_data <= cap;
    @(posedge clk);
    unit_cap = cap;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [20:0] pick_code_point();
    int k;
    k = $urandom_range(19);
    if (k < 8) return 21'($urandom_range(16'h007F));
    if (k < 12) return 21'($urandom_range(16'h07FF, 16'h0080));
    if (k < 16) return 21'($urandom_range(16'hFFFF, 16'h0800));
    if (k < 19) return 21'($urandom_range(21'h10FFFF, 21'h10000));
    return 21'($urandom_range(21'h1FFFFF, 21'h110000));
  endfunction

  function automatic void add_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_str_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_str_byte({3'b110, cp[10:6]});
      add_str_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_str_byte({4'b1110, cp[15:12]});
      add_str_byte({2'b10, cp[11:6]});
      add_str_byte({2'b10, cp[5:0]});
    end else begin
      add_str_byte({5'b11110, cp[20:18]});
      add_str_byte({2'b10, cp[17:12]});
      add_str_byte({2'b10, cp[11:6]});
      add_str_byte({2'b10, cp[5:0]});
    end
  endfunction

  // mostly well-formed strings, some broken, some noise
  task automatic run_strings(input int n_bytes);
    int start;
    int kind;
    int n;
    int cut;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      str_bytes.delete();
      kind = $urandom_range(99);
      n = $urandom_range(6, 1);
      if (kind < 85) begin
        repeat (n) add_code_point(pick_code_point());
      end else begin
        repeat (n) add_str_byte(8'($urandom_range(255)));
      end
      if (kind >= 70 && kind < 85) begin
        cut = $urandom_range(str_bytes.size() - 1);
        if ($urandom_range(1)) str_bytes[cut] = 8'($urandom_range(255));
        else str_bytes = str_bytes[0:cut];
      end
      foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
      strings_sent++;
    end
  endtask

  task automatic note_mismatch(input string what, input word_t want, input word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected cu=%h unit=%b done=%b last=%b, got cu=%h unit=%b done=%b last=%b",
               $realtime, what, want.cu, want.is_unit, want.done, want.last,
               got.cu, got.is_unit, got.done, got.last);
  endtask

  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{code_unit, unit_valid, string_done, run_last};
      words_checked++;
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = expected_words.pop_front();
        if (got != want) note_mismatch("word mismatch", want, got);
      end
    end
  end

  initial begin
    int hold_left = 0;
    bit hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    #2000000;
    $display("** utf8_to_utf16_transcoder_core: FAILED **");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++)
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].eos, DIR_ROWS[i].typed, DIR_ROWS[i].cu);
    strings_sent += 3;
    run_strings(30);
    settle();

    set_limits(1'b1, 16'd0);
    run_strings(15);
    settle();

    set_limits(1'b1, 16'd3);
    calm = 1'b1;
    run_strings(30);
    calm = 1'b0;
    settle();

    set_limits(1'b1, 16'hFFFF);
    hold_go = 1'b1;
    run_strings(25);
    settle();

    set_limits(1'b0, 16'd0);
    run_strings(25);
    settle();

    set_limits(1'b1, 16'($urandom_range(10, 1)));
    run_strings(35);
    settle();

    $display("Sent %0d bytes in %0d strings under %0d limit settings.",
             bytes_sent, strings_sent, settings_run);
    $display("Compared %0d result words; %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("** utf8_to_utf16_transcoder_core: PASSED **");
    end else begin
      $display("** utf8_to_utf16_transcoder_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/u8u16_pkg.sv
sv/u8u16_front.sv
sv/u8u16_queue.sv
sv/u8u16_back.sv
sv/utf8_to_utf16_transcoder_core.sv
bench/utf8_to_utf16_transcoder_core_tb.sv
